// ===== src/pcmrms_pkg.sv =====
package pcmrms_pkg;

	localparam int SUM_W      = 42;
	localparam int SQCNT_W    = 12;
	localparam int LVL_W      = 16;
	localparam int QUO_W      = 31;
	localparam int ROOT_W     = 32;
	localparam int STEP_W     = 6;
	localparam int DIV_STEPS  = 42;
	localparam int SQRT_STEPS = 16;

	localparam logic [SQCNT_W-1:0] SQCNT_MAX  = 12'd4095;
	localparam logic [LVL_W-1:0]   FULL_SCALE = 16'd32768;

	localparam logic [1:0] SB_WIDE = 2'd3;

	localparam logic [1:0] CFG_SAMPLE_BYTES  = 2'd0;
	localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_LEVEL  = 1'b1;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   sum;
		logic [SQCNT_W-1:0] count;
	} lvl_req_t;

	typedef struct packed {
		logic             done;
		logic [LVL_W-1:0] level;
	} lvl_rsp_t;

endpackage

// ===== src/pcmrms_lvl_calc.sv =====
module pcmrms_lvl_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcmrms_pkg::lvl_req_t req,
	output pcmrms_pkg::lvl_rsp_t rsp
);
	import pcmrms_pkg::*;

	typedef enum logic [1:0] {
		C_IDLE,
		C_DIV,
		C_SQRT
	} calc_state_t;

	calc_state_t        state_q;
	logic [SUM_W-1:0]   num_q;
	logic [SQCNT_W-1:0] den_q;
	logic [SQCNT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [ROOT_W-1:0]  v_q;
	logic [ROOT_W-1:0]  res_q;
	logic [ROOT_W-1:0]  bit_q;
	logic               done_q;
	logic [LVL_W-1:0]   level_q;

	logic [SQCNT_W:0]   rem_sh;
	logic               q_bit;
	logic [SQCNT_W-1:0] rem_nxt;
	logic [SUM_W-1:0]   num_nxt;
	logic [ROOT_W-1:0]  trial;
	logic [ROOT_W-1:0]  v_nxt;
	logic [ROOT_W-1:0]  res_nxt;

	// one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, num_q[SUM_W-1]};
		q_bit   = (rem_sh >= {1'b0, den_q});
		rem_nxt = q_bit ? SQCNT_W'(rem_sh - {1'b0, den_q}) : rem_sh[SQCNT_W-1:0];
		num_nxt = {num_q[SUM_W-2:0], q_bit};
	end

	// one root bit per cycle
	always_comb begin
		trial = res_q + bit_q;
		if (v_q >= trial) begin
			v_nxt   = v_q - trial;
			res_nxt = (res_q >> 1) + bit_q;
		end else begin
			v_nxt   = v_q;
			res_nxt = res_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			num_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			v_q     <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			done_q  <= 1'b0;
			level_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						num_q   <= req.sum;
						den_q   <= req.count;
						rem_q   <= '0;
						step_q  <= STEP_W'(DIV_STEPS - 1);
						state_q <= C_DIV;
					end
				end
				C_DIV: begin
					num_q <= num_nxt;
					rem_q <= rem_nxt;
					if (step_q == '0) begin
						v_q     <= ROOT_W'(num_nxt[QUO_W-1:0]);
						res_q   <= '0;
						bit_q   <= ROOT_W'(1) << (2 * SQRT_STEPS - 2);
						step_q  <= STEP_W'(SQRT_STEPS - 1);
						state_q <= C_SQRT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				C_SQRT: begin
					v_q   <= v_nxt;
					res_q <= res_nxt;
					bit_q <= bit_q >> 2;
					if (step_q == '0) begin
						level_q <= (res_nxt > ROOT_W'(FULL_SCALE)) ? FULL_SCALE
							: res_nxt[LVL_W-1:0];
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_comb begin
		rsp.done  = done_q;
		rsp.level = level_q;
	end

endmodule

// ===== src/pcm_channel_rms_meter.sv =====
// channel   direction  handshake              payload
// sample    in         sample_valid/stall     sample_raw, packet_end
// result    out        result_valid/stall     kind, pcm_sample, channel, level, last
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a sample is accepted with a memory read, then added and written back
// at packet end each active channel with samples goes through memory read,
// 42-step divider, 16-step root and result send; a silent channel skips the divider and root
// reset clears the per-channel valid bits at once; no clearing pass
// a stalled result holds the block in its send step; one result register
module pcm_channel_rms_meter #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [23:0]        sample_raw,
	input  logic               packet_end,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               kind,
	output logic signed [15:0] pcm_sample,
	output logic [2:0]         channel,
	output logic [15:0]        level,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_data
);
	import pcmrms_pkg::*;

	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
	localparam int ACC_W = SUM_W + SQCNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_SSEND,
		ST_LRD,
		ST_LWAIT,
		ST_LCALC,
		ST_LSEND
	} state_t;

	state_t state_q;

	logic [1:0] sample_bytes_q;
	logic [3:0] channel_count_q;
	logic [CH_W-1:0] chan_pos_q;
	logic [CH_W-1:0] c_q;
	logic [MAX_CHANNELS-1:0] sum_vld_q;
	logic [MAX_CHANNELS-1:0] lvl_vld_q;
	logic acc_rd_vld_q;
	logic lvl_rd_vld_q;
	logic [LVL_W-1:0] lvl_val_q;

	logic [ACC_W-1:0] acc_mem [MAX_CHANNELS];
	logic [LVL_W-1:0] lvl_mem [MAX_CHANNELS];
	logic [ACC_W-1:0] acc_rd_q;
	logic [LVL_W-1:0] lvl_rd_q;

	logic [15:0]     pcm_s1;
	logic [31:0]     sq_s1;
	logic            end_s1;
	logic [CH_W-1:0] ch_s1;

	logic            result_valid_q;
	logic            kind_q;
	logic [15:0]     pcm_q;
	logic [2:0]      channel_q;
	logic [LVL_W-1:0] level_q;
	logic            last_q;

	logic [4:0]       n_raw;
	logic [NCH_W-1:0] n_act;
	logic [CH_W-1:0]  ch_sel;
	logic [NCH_W-1:0] ch_inc;
	logic [CH_W-1:0]  pos_nxt;
	logic             accept;
	logic [15:0]      pcm_in;
	logic signed [15:0] sv;
	logic signed [31:0] sq_full;

	logic               rd_en;
	logic [CH_W-1:0]    rd_addr;
	logic [SUM_W-1:0]   sum_old;
	logic [SQCNT_W-1:0] cnt_old;
	logic               acc_we;
	logic [ACC_W-1:0]   acc_wdata;
	logic               lvl_we;
	logic               has_data;
	logic               lvl_last;

	logic             out_free;
	logic             out_load;
	logic             ld_kind;
	logic [15:0]      ld_pcm;
	logic [2:0]       ld_ch;
	logic [LVL_W-1:0] ld_lvl;
	logic             ld_last;

	lvl_req_t lvl_req;
	lvl_rsp_t lvl_rsp;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;

	// active channel count and channel of the incoming sample
	always_comb begin
		n_raw = (channel_count_q == 4'd0) ? 5'd2 : {1'b0, channel_count_q};
		if (n_raw > 5'(MAX_CHANNELS))
			n_raw = 5'(MAX_CHANNELS);
		n_act   = NCH_W'(n_raw);
		ch_sel  = (NCH_W'(chan_pos_q) < n_act) ? chan_pos_q : '0;
		ch_inc  = NCH_W'(ch_s1) + 1'b1;
		pos_nxt = (ch_inc >= n_act) ? '0 : CH_W'(ch_inc);
	end

	always_comb begin
		pcm_in  = (sample_bytes_q == SB_WIDE) ? sample_raw[23:8] : sample_raw[15:0];
		sv      = signed'(pcm_in);
		sq_full = sv * sv;
	end

	// read-modify-write of the channel accumulator
	always_comb begin
		rd_en     = accept || (state_q == ST_LRD);
		rd_addr   = (state_q == ST_LRD) ? c_q : ch_sel;
		sum_old   = acc_rd_vld_q ? acc_rd_q[ACC_W-1:SQCNT_W] : '0;
		cnt_old   = acc_rd_vld_q ? acc_rd_q[SQCNT_W-1:0] : '0;
		acc_we    = (state_q == ST_ACC) && (cnt_old < SQCNT_MAX);
		acc_wdata = {SUM_W'(sum_old + SUM_W'(sq_s1)), SQCNT_W'(cnt_old + 1'b1)};
		has_data  = acc_rd_vld_q && (acc_rd_q[SQCNT_W-1:0] != '0);
		lvl_we    = (state_q == ST_LCALC) && lvl_rsp.done;
		lvl_last  = (NCH_W'(c_q) + 1'b1) == n_act;
	end

	always_comb begin
		lvl_req.start = (state_q == ST_LWAIT) && has_data;
		lvl_req.sum   = acc_rd_q[ACC_W-1:SQCNT_W];
		lvl_req.count = acc_rd_q[SQCNT_W-1:0];
	end

	pcmrms_lvl_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lvl_req),
		.rsp    (lvl_rsp)
	);

	// result register loading
	always_comb begin
		out_free = !result_valid_q || !result_stall;
		ld_kind  = KIND_SAMPLE;
		ld_pcm   = pcm_s1;
		ld_ch    = 3'(ch_s1);
		ld_lvl   = '0;
		ld_last  = !end_s1;
		out_load = 1'b0;
		unique case (state_q)
			ST_ACC, ST_SSEND: out_load = out_free;
			ST_LSEND: begin
				out_load = out_free;
				ld_kind  = KIND_LEVEL;
				ld_pcm   = '0;
				ld_ch    = 3'(c_q);
				ld_lvl   = lvl_val_q;
				ld_last  = lvl_last;
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[ch_s1] <= acc_wdata;
		if (rd_en)
			acc_rd_q <= acc_mem[rd_addr];
		if (lvl_we)
			lvl_mem[c_q] <= lvl_rsp.level;
		if (rd_en)
			lvl_rd_q <= lvl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sample_bytes_q  <= 2'd2;
			channel_count_q <= 4'd2;
			chan_pos_q      <= '0;
			c_q             <= '0;
			sum_vld_q       <= '0;
			lvl_vld_q       <= '0;
			acc_rd_vld_q    <= 1'b0;
			lvl_rd_vld_q    <= 1'b0;
			lvl_val_q       <= '0;
			pcm_s1          <= '0;
			sq_s1           <= '0;
			end_s1          <= 1'b0;
			ch_s1           <= '0;
			result_valid_q  <= 1'b0;
			kind_q          <= KIND_SAMPLE;
			pcm_q           <= '0;
			channel_q       <= '0;
			level_q         <= '0;
			last_q          <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SAMPLE_BYTES:  sample_bytes_q  <= cfg_data[1:0];
					CFG_CHANNEL_COUNT: channel_count_q <= cfg_data;
					default: ;
				endcase
			end

			if (rd_en) begin
				acc_rd_vld_q <= sum_vld_q[rd_addr];
				lvl_rd_vld_q <= lvl_vld_q[rd_addr];
			end

			if (out_load) begin
				result_valid_q <= 1'b1;
				kind_q         <= ld_kind;
				pcm_q          <= ld_pcm;
				channel_q      <= ld_ch;
				level_q        <= ld_lvl;
				last_q         <= ld_last;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pcm_s1  <= pcm_in;
						sq_s1   <= unsigned'(sq_full);
						end_s1  <= packet_end;
						ch_s1   <= ch_sel;
						state_q <= ST_ACC;
					end
				end
				ST_ACC, ST_SSEND: begin
					if (state_q == ST_ACC) begin
						if (acc_we)
							sum_vld_q[ch_s1] <= 1'b1;
						chan_pos_q <= end_s1 ? '0 : pos_nxt;
					end
					if (out_load) begin
						c_q     <= '0;
						state_q <= end_s1 ? ST_LRD : ST_IDLE;
					end else begin
						state_q <= ST_SSEND;
					end
				end
				ST_LRD: state_q <= ST_LWAIT;
				ST_LWAIT: begin
					if (has_data) begin
						state_q <= ST_LCALC;
					end else begin
						lvl_val_q <= lvl_rd_vld_q ? lvl_rd_q : '0;
						state_q   <= ST_LSEND;
					end
				end
				ST_LCALC: begin
					if (lvl_rsp.done) begin
						lvl_val_q      <= lvl_rsp.level;
						lvl_vld_q[c_q] <= 1'b1;
						state_q        <= ST_LSEND;
					end
				end
				ST_LSEND: begin
					if (out_load) begin
						if (lvl_last) begin
							sum_vld_q  <= '0;
							chan_pos_q <= '0;
							state_q    <= ST_IDLE;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= ST_LRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = kind_q;
	assign pcm_sample   = signed'(pcm_q);
	assign channel      = channel_q;
	assign level        = level_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ACC))
		else $error("accepted item did not reach accumulate step");

	a_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_LEVEL) |-> (level <= FULL_SCALE))
		else $error("level above full scale");

	a_packet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LSEND && out_load && lvl_last)
			|=> (sum_vld_q == '0 && state_q == ST_IDLE && chan_pos_q == '0))
		else $error("accumulators not cleared at packet end");

	a_calc_start: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_req.start |=> (state_q == ST_LCALC && !lvl_rsp.done))
		else $error("level calculation start out of sequence");
`endif

endmodule

// ===== dv/pcm_channel_rms_meter_test.sv =====
`timescale 1ns / 1ps

module pcm_channel_rms_meter_test;

	import pcmrms_pkg::*;

	localparam int MAX_CH = 8;
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;
	localparam logic [1:0] SB_NARROW = 2'd2;
	localparam logic [1:0] SB_ZERO = 2'd0;
	localparam logic [1:0] SB_ONE = 2'd1;

	typedef struct {
		logic [23:0] raw;
		logic        pend;
	} sample_item_t;

	typedef struct {
		logic        kind;
		logic [15:0] pcm;
		logic [2:0]  chan;
		logic [15:0] lvl;
		logic        last;
	} meter_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic [23:0]        sample_raw = '0;
	logic               packet_end = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               kind;
	logic signed [15:0] pcm_sample;
	logic [2:0]         channel;
	logic [15:0]        level;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [3:0]         cfg_data = '0;

	pcm_channel_rms_meter #(
		.MAX_CHANNELS(MAX_CH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_raw(sample_raw),
		.packet_end(packet_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.pcm_sample(pcm_sample),
		.channel(channel),
		.level(level),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sample_item_t  pending_samples[$];
	meter_result_t expected_results[$];
	int            error_count = 0;
	bit            no_idle = 1'b0;
	int unsigned   sample_gap = 0;
	int unsigned   stall_left = 0;
	sample_item_t  drive_item;
	meter_result_t want_r;

	// shadow of the meter
	logic [1:0]         cfg_sb = 2'd2;
	logic [3:0]         cfg_cc = 4'd2;
	logic [2:0]         pos = '0;
	logic [SUM_W-1:0]   sums[MAX_CH];
	logic [SQCNT_W-1:0] cnts[MAX_CH];
	logic [LVL_W-1:0]   lvls[MAX_CH];

	initial begin
		for (int i = 0; i < MAX_CH; i++) begin
			sums[i] = '0;
			cnts[i] = '0;
			lvls[i] = '0;
		end
	end

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned active_count();
		if (cfg_cc == 4'd0)
			return 2;
		if (cfg_cc > MAX_CH)
			return MAX_CH;
		return 32'(cfg_cc);
	endfunction

	function automatic logic [31:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] probe;
		res = '0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res[31:0];
	endfunction

	task automatic meter_predict(input logic [23:0] raw, input logic pend);
		int unsigned        n;
		logic [2:0]         ch;
		logic [15:0]        pcm;
		logic signed [15:0] sv;
		int                 sx;
		int                 prod;
		logic [SUM_W-1:0]   sq;
		logic [63:0]        quo;
		logic [31:0]        root;
		meter_result_t      r;
		n = active_count();
		ch = (pos < n) ? pos : 3'd0;
		pcm = (cfg_sb == SB_WIDE) ? raw[23:8] : raw[15:0];
		sv = signed'(pcm);
		sx = int'(sv);
		prod = sx * sx;
		sq = SUM_W'(prod);
		if (cnts[ch] < SQCNT_MAX) begin
			sums[ch] = sums[ch] + sq;
			cnts[ch] = cnts[ch] + 1'b1;
		end
		pos = (ch + 1 >= n) ? 3'd0 : 3'(ch + 1);
		r = '{KIND_SAMPLE, pcm, ch, 16'd0, !pend};
		expected_results = {expected_results, r};
		if (pend) begin
			for (int c = 0; c < n; c++) begin
				if (cnts[c] > 0) begin
					quo = 64'(sums[c]) / 64'(cnts[c]);
					root = isqrt64(quo);
					if (root > FULL_SCALE)
						root = 32'(FULL_SCALE);
					lvls[c] = root[15:0];
				end
				r = '{KIND_LEVEL, 16'd0, 3'(c), lvls[c], (c + 1 == n)};
				expected_results = {expected_results, r};
			end
			for (int c = 0; c < MAX_CH; c++) begin
				sums[c] = '0;
				cnts[c] = '0;
			end
			pos = '0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample_raw <= '0;
			packet_end <= 1'b0;
			sample_gap = 0;
		end else begin
			if (sample_valid && !sample_stall)
				meter_predict(sample_raw, packet_end);
			if (!sample_valid || !sample_stall) begin
				if (sample_gap > 0) begin
					sample_gap--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					drive_item = pending_samples.pop_front();
					sample_raw <= drive_item.raw;
					packet_end <= drive_item.pend;
					sample_valid <= 1'b1;
					sample_gap = no_idle ? 0 : pick_gap();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (no_idle || $urandom_range(0, 99) < 70) begin
			result_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			result_stall <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind %0b channel %0d",
					kind, channel));
			end else begin
				want_r = expected_results.pop_front();
				check_field("kind", 16'(kind), 16'(want_r.kind));
				check_field("pcm_sample", pcm_sample, want_r.pcm);
				check_field("channel", 16'(channel), 16'(want_r.chan));
				check_field("level", level, want_r.lvl);
				check_field("last", 16'(last), 16'(want_r.last));
			end
		end
	end

	task automatic add_sample(input logic [23:0] raw, input logic pend);
		sample_item_t s;
		s.raw = raw;
		s.pend = pend;
		pending_samples = {pending_samples, s};
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [3:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SAMPLE_BYTES)
			cfg_sb = val[1:0];
		else if (idx == CFG_CHANNEL_COUNT)
			cfg_cc = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return {8'($urandom), 16'h8000};
			3: return {8'($urandom), 16'h7FFF};
			4: return {16'h8000, 8'($urandom)};
			5: return {16'h7FFF, 8'($urandom)};
			6: return 24'($urandom_range(0, 63));
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		logic [1:0]  sb_list[10];
		logic [3:0]  cc_list[10];
		int unsigned n;
		int unsigned len;
		int          total;
		sb_list = '{SB_NARROW, SB_WIDE, SB_ZERO, SB_WIDE, SB_ONE,
			SB_WIDE, SB_NARROW, SB_WIDE, SB_ZERO, SB_WIDE};
		cc_list = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd5, 4'd9, 4'd3, 4'd2, 4'd7, 4'd6};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, full scale on both channels
		add_sample(24'h008000, 1'b0);
		add_sample(24'h008000, 1'b0);
		add_sample(24'h008000, 1'b0);
		add_sample(24'hFF8000, 1'b1);
		add_sample(24'hAB7FFF, 1'b0);
		add_sample(24'h000000, 1'b1);
		wait_drain();

		// 24-bit, four channels, then a short packet leaves two silent
		cfg_write(CFG_SAMPLE_BYTES, 4'(SB_WIDE));
		cfg_write(CFG_CHANNEL_COUNT, 4'd4);
		add_sample(24'h800000, 1'b0);
		add_sample(24'h7FFFFF, 1'b0);
		add_sample(24'h0000FF, 1'b0);
		add_sample(24'hFFFF00, 1'b1);
		add_sample(24'h123456, 1'b0);
		add_sample(24'hFEDCBA, 1'b1);
		wait_drain();

		// channel count shrinks inside a packet
		cfg_write(CFG_CHANNEL_COUNT, 4'd8);
		for (int i = 0; i < 6; i++)
			add_sample(pick_raw(), 1'b0);
		wait_drain();
		cfg_write(CFG_CHANNEL_COUNT, 4'd3);
		add_sample(24'h400000, 1'b0);
		add_sample(24'hC00000, 1'b1);
		wait_drain();

		// writes past the register list change nothing
		cfg_write(CFG_SPARE_A, 4'hF);
		cfg_write(CFG_SPARE_B, 4'h0);
		add_sample(24'h00FF00, 1'b0);
		add_sample(24'hFF00FF, 1'b0);
		add_sample(24'h55AA55, 1'b1);
		wait_drain();

		for (int ph = 0; ph < 10; ph++) begin
			cfg_write(CFG_SAMPLE_BYTES, {2'($urandom), sb_list[ph]});
			cfg_write(CFG_CHANNEL_COUNT, cc_list[ph]);
			if ($urandom_range(0, 2) == 0)
				cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 4'($urandom));
			no_idle = (ph == 4);
			n = active_count();
			total = 0;
			while (total < 26) begin
				len = $urandom_range(1, 3 * n + 2);
				for (int i = 0; i < len; i++)
					add_sample(pick_raw(),
						(i == len - 1) && ($urandom_range(0, 9) != 0));
				total += len;
			end
			wait_drain();
		end
		no_idle = 1'b0;

		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("pcm_channel_rms_meter_test: clean");
		else
			$display("pcm_channel_rms_meter_test: errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("pcm_channel_rms_meter_test: errors");
		$finish;
	end

endmodule
